// File: hdl/dcalu_pkg.sv
`default_nettype none

package dcalu_pkg;

    // operation codes on s_action
    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_DIV = 2'd2;

    localparam int DEC_BASE = 10;
    // floor(s * 205 / 2048) == floor(s / 10) for every s below 1024
    localparam logic [15:0] DEC_RECIP = 16'd205;
    localparam int DEC_RECIP_SHIFT = 11;

    localparam int DIGIT_W = 8;
    localparam int DIV_W = 16;
    // remainder * 10 + digit needs 20 bits
    localparam int OP_W = 20;
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES = OP_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            done;
        logic [OP_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_res_t;

endpackage

`default_nettype wire

// File: hdl/dcalu_div.sv
`default_nettype none

module dcalu_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [dcalu_pkg::OP_W-1:0]  op,
    input  wire logic [dcalu_pkg::DIV_W-1:0] divisor,
    output dcalu_pkg::div_res_t            res
);
    import dcalu_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [OP_W-1:0]      quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [OP_W-1:0]      quo_next;

    // restoring division, a few quotient bits per cycle; quo_reg shifts the
    // dividend out at the top and the quotient in at the bottom
    always_comb begin
        logic [DIV_W:0]  r;
        logic [OP_W-1:0] q;
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            r = {r[DIV_W-1:0], q[OP_W-1]};
            q = {q[OP_W-2:0], 1'b0};
            if (r >= {1'b0, dvs_reg}) begin
                r = r - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r[DIV_W-1:0];
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= op;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

`default_nettype wire

// File: hdl/decimal_digit_serial_alu.sv
// Digit-serial decimal add / subtract / divide-by-integer unit.
// Input channel s_*: one digit position per transfer (action, first flag,
// a digit, b digit). Add and subtract take digits least significant first,
// divide takes them most significant first. A set first flag clears the
// carry and the running remainder before the digit is used.
// Result channel m_*: one result per input transfer, in order.
// divisor_we / divisor_wdata write the divisor; write it only between
// operations. Reset sets the divisor to 1 and clears carry and remainder.
// Add, subtract and unused codes go from the input transfer into the
// working result register, then into the output register. Divide runs a
// restoring divider, 4 quotient bits per cycle over the 20-bit dividend,
// into the working result; a zero divisor skips the divider. A new
// item is taken only once the last result is in the output register.
// The result sits in an output register separate from the working result,
// so the next item is taken while m_ready is low; when the receiver stalls,
// the finished working result holds until the output register frees up.
`default_nettype none

module decimal_digit_serial_alu_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           divisor_we,
    input  wire logic [dcalu_pkg::DIV_W-1:0]    divisor_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_action,
    input  wire logic                           s_first,
    input  wire logic [dcalu_pkg::DIGIT_W-1:0]  s_a_digit,
    input  wire logic [3:0]                     s_b_digit,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [dcalu_pkg::DIGIT_W-1:0]       m_result_digit,
    output logic                                m_carry_out,
    output logic [dcalu_pkg::DIV_W-1:0]         m_remainder_out
);
    import dcalu_pkg::*;

    state_t             state_reg, state_next;
    logic [DIV_W-1:0]   divisor_reg;
    logic               carry_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0] p_digit_reg;
    logic               p_carry_reg;
    logic [DIV_W-1:0]   p_rem_reg;
    logic               m_valid_reg;
    logic [DIGIT_W-1:0] m_digit_reg;
    logic               m_carry_reg;
    logic [DIV_W-1:0]   m_rem_reg;

    logic               take;
    logic               div_start;
    logic               out_load;
    div_res_t           div_res;

    logic               c_eff;
    logic [DIV_W-1:0]   rem_eff;
    logic [8:0]         add_sum;
    logic [15:0]        add_prod;
    logic [4:0]         add_quo;
    logic [8:0]         add_rem;
    logic               add_carry;
    logic [4:0]         sub_amt;
    logic               sub_borrow;
    logic [DIGIT_W-1:0] sub_digit;
    logic [OP_W-1:0]    div_op;
    logic [DIGIT_W-1:0] div_digit;
    logic               div_zero;

    assign c_eff   = s_first ? 1'b0 : carry_reg;
    assign rem_eff = s_first ? '0 : rem_reg;

    // add: digit = sum mod 10 through a reciprocal multiply
    assign add_sum   = {1'b0, s_a_digit} + {5'b0, s_b_digit} + {8'b0, c_eff};
    assign add_prod  = {7'b0, add_sum} * DEC_RECIP;
    assign add_quo   = add_prod[DEC_RECIP_SHIFT +: 5];
    assign add_rem   = add_sum - ({4'b0, add_quo} * 9'(DEC_BASE));
    assign add_carry = add_sum >= 9'(DEC_BASE);

    assign sub_amt    = {1'b0, s_b_digit} + {4'b0, c_eff};
    assign sub_borrow = s_a_digit < {3'b0, sub_amt};
    assign sub_digit  = sub_borrow ? s_a_digit + 8'(DEC_BASE) - {3'b0, sub_amt}
                                   : s_a_digit - {3'b0, sub_amt};

    // remainder * 10 + digit
    assign div_op = ({4'b0, rem_eff} << 3) + ({4'b0, rem_eff} << 1)
                  + {12'b0, s_a_digit};
    assign div_zero  = divisor_reg == '0;
    assign div_digit = (|div_res.quo[OP_W-1:DIGIT_W]) ? '1 : div_res.quo[DIGIT_W-1:0];

    dcalu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .op      (div_op),
        .divisor (divisor_reg),
        .res     (div_res)
    );

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == ACT_DIV && !div_zero) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            divisor_reg <= DIV_W'(1);
            carry_reg   <= 1'b0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (divisor_we) begin
                divisor_reg <= divisor_wdata;
            end
            if (take) begin
                case (s_action)
                    ACT_ADD: begin
                        carry_reg <= add_carry;
                        rem_reg   <= rem_eff;
                    end
                    ACT_SUB: begin
                        carry_reg <= sub_borrow;
                        rem_reg   <= rem_eff;
                    end
                    ACT_DIV: begin
                        carry_reg <= c_eff;
                        rem_reg   <= div_zero ? '0 : rem_eff;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_DIV && div_res.done) begin
                rem_reg <= div_res.rem;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            case (s_action)
                ACT_ADD: begin
                    p_digit_reg <= {4'b0, add_rem[3:0]};
                    p_carry_reg <= add_carry;
                    p_rem_reg   <= '0;
                end
                ACT_SUB: begin
                    p_digit_reg <= sub_digit;
                    p_carry_reg <= sub_borrow;
                    p_rem_reg   <= '0;
                end
                ACT_DIV: begin
                    p_digit_reg <= '1;
                    p_carry_reg <= 1'b0;
                    p_rem_reg   <= '0;
                end
                default: begin
                    p_digit_reg <= '0;
                    p_carry_reg <= 1'b0;
                    p_rem_reg   <= '0;
                end
            endcase
        end else if (state_reg == ST_DIV && div_res.done) begin
            p_digit_reg <= div_digit;
            p_carry_reg <= 1'b0;
            p_rem_reg   <= div_res.rem;
        end
        if (out_load) begin
            m_digit_reg <= p_digit_reg;
            m_carry_reg <= p_carry_reg;
            m_rem_reg   <= p_rem_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_digit  = m_digit_reg;
    assign m_carry_out     = m_carry_reg;
    assign m_remainder_out = m_rem_reg;

endmodule

`default_nettype wire

// File: hdl/dcalu_chk.sv
`default_nettype none

module dcalu_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_result_digit,
    input wire logic        m_carry_out,
    input wire logic [15:0] m_remainder_out
);

    // result holds while the receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_digit)
            && $stable(m_carry_out) && $stable(m_remainder_out))
        else $error("result changed during stall");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // carry belongs to add/subtract, remainder to divide
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_carry_out && m_remainder_out != 16'd0))
        else $error("carry and remainder both set");

endmodule

bind decimal_digit_serial_alu_unit dcalu_chk u_dcalu_chk (.*);

`default_nettype wire
